### src/odo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package odo_pkg;

	localparam int CORDIC_STEPS = 24;

	localparam logic [31:0] K_VEL       = 32'd25749214;
	localparam logic [31:0] K_YAW       = 32'd3069545;
	localparam logic [31:0] K_US        = 32'd1125899907;
	localparam logic [31:0] K_HEAD      = 32'd751587969;
	localparam logic [33:0] CORDIC_GAIN = 34'h026DD3B6A;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_RADIUS    = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_EFFECTIVE_TRACK = 8'd1;

	typedef struct packed {
		logic signed [15:0] count_front_left;
		logic signed [15:0] count_front_right;
		logic signed [15:0] count_rear_left;
		logic signed [15:0] count_rear_right;
		logic [19:0]        interval_us;
	} tick_t;

	typedef struct packed {
		logic signed [31:0] linear_velocity;
		logic signed [31:0] yaw_rate;
		logic signed [47:0] position_x;
		logic signed [47:0] position_y;
		logic [31:0]        heading_angle;
	} result_t;

	function automatic logic [31:0] atan_at(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sat32(input logic neg, input logic [63:0] m);
		logic [31:0] r;
		if (neg) begin
			r = (m >= 64'h80000000) ? 32'h80000000 : 32'(64'd0 - m);
		end else begin
			r = (m >= 64'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? 32'd0 - v : v;
	endfunction

endpackage

`default_nettype wire

### src/differential_drive_odometry.sv
// A new request is taken only when the sequencer is idle, so each request runs through the
// CORDIC loop, ten passes through the shared 32x32 multiplier and a radix-2 divider
// before the next one is accepted.
// A new request is accepted while the previous result still waits in the output register.
// Asynchronous active-low reset clears position, heading, velocity and the sequencer and
// restores wheel radius 50000 um and effective track 2000000 um.
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_odometry (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           tick_valid,
	output logic                          tick_ready,
	input  odo_pkg::tick_t                tick,
	output logic                          result_valid,
	input  wire                           result_ready,
	output odo_pkg::result_t              result,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [odo_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire [odo_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import odo_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CORDIC = 3'd1;
	localparam logic [2:0] ST_TRIG   = 3'd2;
	localparam logic [2:0] ST_MUL    = 3'd3;
	localparam logic [2:0] ST_DIV    = 3'd4;
	localparam logic [2:0] ST_OUT    = 3'd5;

	localparam logic [3:0] OP_TRAVEL_T = 4'd0;
	localparam logic [3:0] OP_TRAVEL_D = 4'd1;
	localparam logic [3:0] OP_DX       = 4'd2;
	localparam logic [3:0] OP_DY       = 4'd3;
	localparam logic [3:0] OP_VEL_T    = 4'd4;
	localparam logic [3:0] OP_VEL      = 4'd5;
	localparam logic [3:0] OP_YAW_T    = 4'd6;
	localparam logic [3:0] OP_YAW_N    = 4'd7;
	localparam logic [3:0] OP_HEAD_T   = 4'd8;
	localparam logic [3:0] OP_HEAD     = 4'd9;

	localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_STEPS - 1);
	localparam logic [5:0] DIV_LAST    = 6'd59;

	logic [2:0]         state_q;
	logic [3:0]         op_q;
	logic [2:0]         phase_q;
	logic [5:0]         step_q;

	logic [19:0]        radius_q;
	logic [23:0]        track_q;
	logic signed [47:0] pos_x_q;
	logic signed [47:0] pos_y_q;
	logic [31:0]        heading_q;
	logic [31:0]        vel_q;
	logic [31:0]        yaw_q;

	logic [19:0]        dt_q;
	logic [17:0]        sum_mag_q;
	logic               sum_neg_q;
	logic [17:0]        diff_mag_q;
	logic               diff_neg_q;

	logic signed [33:0] cx_q;
	logic signed [33:0] cy_q;
	logic signed [33:0] cz_q;
	logic               flip_q;
	logic [31:0]        cos_mag_q;
	logic               cos_neg_q;
	logic [31:0]        sin_mag_q;
	logic               sin_neg_q;

	logic [63:0]        t_q;
	logic [63:0]        prod_q;
	logic [95:0]        acc_q;
	logic [63:0]        rnd_q;
	logic [59:0]        num_q;
	logic [31:0]        rem_q;

	logic               out_valid_q;
	result_t            out_q;

	logic signed [18:0] sum_in;
	logic signed [18:0] diff_in;
	logic [31:0]        folded;
	logic               fold;
	logic [63:0]        a_sel;
	logic [31:0]        b_sel;
	logic [95:0]        rnd_full;
	logic signed [33:0] xs;
	logic signed [33:0] ys;
	logic [33:0]        atan_ext;
	logic               trav_neg;
	logic signed [49:0] pos_cur;
	logic signed [49:0] pos_delta;
	logic signed [49:0] pos_sum;
	logic signed [47:0] pos_sat;
	logic [23:0]        track_eff;
	logic [32:0]        rem_sh;
	logic               rem_ge;
	logic [32:0]        den;

	assign tick_ready   = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	assign track_eff = (track_q == 24'd0) ? 24'd1 : track_q;
	assign den       = {1'b0, track_eff, 8'd0};

	always_comb begin
		sum_in  = 19'(tick.count_front_left) + 19'(tick.count_front_right)
			+ 19'(tick.count_rear_left) + 19'(tick.count_rear_right);
		diff_in = (19'(tick.count_front_right) + 19'(tick.count_rear_right))
			- (19'(tick.count_front_left) + 19'(tick.count_rear_left));
		fold    = (heading_q > 32'h40000000) && (heading_q < 32'hC0000000);
		folded  = fold ? heading_q + 32'h80000000 : heading_q;
	end

	always_comb begin
		case (op_q)
			OP_TRAVEL_T: begin
				a_sel = {32'd0, mag32(vel_q)};
				b_sel = {12'd0, dt_q};
			end
			OP_TRAVEL_D: begin
				a_sel = t_q;
				b_sel = K_US;
			end
			OP_DX: begin
				a_sel = t_q;
				b_sel = cos_mag_q;
			end
			OP_DY: begin
				a_sel = t_q;
				b_sel = sin_mag_q;
			end
			OP_VEL_T: begin
				a_sel = {46'd0, sum_mag_q};
				b_sel = {12'd0, radius_q};
			end
			OP_VEL: begin
				a_sel = t_q;
				b_sel = K_VEL;
			end
			OP_YAW_T: begin
				a_sel = {46'd0, diff_mag_q};
				b_sel = {12'd0, radius_q};
			end
			OP_YAW_N: begin
				a_sel = t_q;
				b_sel = K_YAW;
			end
			OP_HEAD_T: begin
				a_sel = {32'd0, mag32(yaw_q)};
				b_sel = {12'd0, dt_q};
			end
			OP_HEAD: begin
				a_sel = t_q;
				b_sel = K_HEAD;
			end
			default: begin
				a_sel = 64'd0;
				b_sel = 32'd0;
			end
		endcase
	end

	always_comb begin
		case (op_q)
			OP_TRAVEL_D: rnd_full = (acc_q + (96'd1 << 29)) >> 30;
			OP_DX, OP_DY: rnd_full = (acc_q + (96'd1 << 49)) >> 50;
			OP_VEL: rnd_full = (acc_q + (96'd1 << 31)) >> 32;
			OP_HEAD: rnd_full = (acc_q + (96'd1 << 39)) >> 40;
			default: rnd_full = acc_q;
		endcase
	end

	always_comb begin
		xs       = cx_q >>> step_q[4:0];
		ys       = cy_q >>> step_q[4:0];
		atan_ext = {2'd0, atan_at(step_q[4:0])};
	end

	always_comb begin
		trav_neg  = (op_q == OP_DX) ? (vel_q[31] ^ cos_neg_q) : (vel_q[31] ^ sin_neg_q);
		pos_cur   = (op_q == OP_DX) ? 50'(pos_x_q) : 50'(pos_y_q);
		pos_delta = {16'd0, rnd_q[33:0]};
		pos_sum   = trav_neg ? pos_cur - pos_delta : pos_cur + pos_delta;
		if (pos_sum[49:47] == 3'b000 || pos_sum[49:47] == 3'b111) begin
			pos_sat = pos_sum[47:0];
		end else if (pos_sum[49]) begin
			pos_sat = {1'b1, 47'd0};
		end else begin
			pos_sat = {1'b0, {47{1'b1}}};
		end
	end

	always_comb begin
		rem_sh = {rem_q, num_q[59]};
		rem_ge = (rem_sh >= den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_TRAVEL_T;
			phase_q     <= 3'd0;
			step_q      <= 6'd0;
			radius_q    <= 20'd50000;
			track_q     <= 24'd2000000;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			heading_q   <= 32'd0;
			vel_q       <= 32'd0;
			yaw_q       <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_WHEEL_RADIUS) begin
					radius_q <= cfg_data[19:0];
				end else if (cfg_index == REG_EFFECTIVE_TRACK) begin
					track_q <= cfg_data;
				end
			end
			if (state_q == ST_OUT) begin
				if (!out_valid_q || result_ready) begin
					out_valid_q <= 1'b1;
				end
			end else if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (tick_valid) begin
						state_q <= ST_CORDIC;
						step_q  <= 6'd0;
					end
				end
				ST_CORDIC: begin
					step_q <= step_q + 6'd1;
					if (step_q == CORDIC_LAST) begin
						state_q <= ST_TRIG;
					end
				end
				ST_TRIG: begin
					state_q <= ST_MUL;
					op_q    <= OP_TRAVEL_T;
					phase_q <= 3'd0;
				end
				ST_MUL: begin
					if (phase_q == 3'd4) begin
						phase_q <= 3'd0;
						case (op_q)
							OP_DX: pos_x_q <= pos_sat;
							OP_DY: pos_y_q <= pos_sat;
							OP_VEL: vel_q <= sat32(sum_neg_q, rnd_q);
							OP_HEAD: heading_q <= diff_neg_q && yaw_q[31]
								? heading_q - rnd_q[31:0]
								: (yaw_q[31] ? heading_q - rnd_q[31:0]
									: heading_q + rnd_q[31:0]);
							default: begin
							end
						endcase
						if (op_q == OP_YAW_N) begin
							state_q <= ST_DIV;
							step_q  <= 6'd0;
						end else if (op_q == OP_HEAD) begin
							state_q <= ST_OUT;
						end else begin
							op_q <= op_q + 4'd1;
						end
					end else begin
						phase_q <= phase_q + 3'd1;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 6'd1;
					if (step_q == DIV_LAST) begin
						state_q <= ST_MUL;
						op_q    <= OP_HEAD_T;
						phase_q <= 3'd0;
						yaw_q   <= sat32(diff_neg_q, {4'd0, num_q[58:0], rem_ge});
					end
				end
				ST_OUT: begin
					if (!out_valid_q || result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dt_q       <= tick.interval_us;
				sum_neg_q  <= sum_in[18];
				sum_mag_q  <= sum_in[18] ? 18'(-sum_in) : sum_in[17:0];
				diff_neg_q <= diff_in[18];
				diff_mag_q <= diff_in[18] ? 18'(-diff_in) : diff_in[17:0];
				cx_q       <= CORDIC_GAIN;
				cy_q       <= '0;
				cz_q       <= 34'(signed'(folded));
				flip_q     <= fold;
			end
			ST_CORDIC: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - signed'(atan_ext);
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + signed'(atan_ext);
				end
			end
			ST_TRIG: begin
				cos_neg_q <= cx_q[33] ^ flip_q;
				cos_mag_q <= cx_q[33] ? 32'(-cx_q) : cx_q[31:0];
				sin_neg_q <= cy_q[33] ^ flip_q;
				sin_mag_q <= cy_q[33] ? 32'(-cy_q) : cy_q[31:0];
			end
			ST_MUL: begin
				case (phase_q)
					3'd0: prod_q <= a_sel[31:0] * b_sel;
					3'd1: begin
						acc_q  <= {32'd0, prod_q};
						prod_q <= a_sel[63:32] * b_sel;
					end
					3'd2: acc_q <= acc_q + {prod_q, 32'd0};
					3'd3: rnd_q <= rnd_full[63:0];
					default: begin
						if (op_q == OP_TRAVEL_T || op_q == OP_TRAVEL_D || op_q == OP_VEL_T
							|| op_q == OP_YAW_T || op_q == OP_HEAD_T) begin
							t_q <= rnd_q;
						end
						if (op_q == OP_YAW_N) begin
							num_q <= rnd_q[59:0] + {29'd0, track_eff, 7'd0};
							rem_q <= 32'd0;
						end
					end
				endcase
			end
			ST_DIV: begin
				rem_q <= rem_ge ? 32'(rem_sh - den) : rem_sh[31:0];
				num_q <= {num_q[58:0], rem_ge};
			end
			ST_OUT: begin
				if (!out_valid_q || result_ready) begin
					out_q.linear_velocity <= vel_q;
					out_q.yaw_rate        <= yaw_q;
					out_q.position_x      <= pos_x_q;
					out_q.position_y      <= pos_y_q;
					out_q.heading_angle   <= heading_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
